>>> hdl/ehf_pkg.sv
// shared types and constants of the ethernet ipv4 l4 header filter
`default_nettype none

package ehf_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 65536;
	localparam int unsigned POS_W = 16;
	localparam int unsigned AVAIL_W = 17;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;
	localparam logic [AVAIL_W-1:0] MIN_DECODE_BYTES = 17'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROTOCOL_SELECT = 3'd0,
		REG_MATCH_ENABLES   = 3'd1,
		REG_WANT_SRC_MAC    = 3'd2,
		REG_WANT_DST_MAC    = 3'd3,
		REG_WANT_SRC_IP     = 3'd4,
		REG_WANT_DST_IP     = 3'd5,
		REG_WANT_SRC_PORT   = 3'd6,
		REG_WANT_DST_PORT   = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT      = 2'd0,
		VERDICT_PROTO_DROP  = 2'd1,
		VERDICT_MATCH_DROP  = 2'd2,
		VERDICT_TRUNCATED   = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		CLASS_TCP   = 2'd0,
		CLASS_UDP   = 2'd1,
		CLASS_OTHER = 2'd2,
		CLASS_NONE  = 2'd3
	} class_t;

	typedef struct packed {
		logic [7:0]  protocol_select;
		logic [3:0]  match_enables;
		logic [47:0] want_src_mac;
		logic [47:0] want_dst_mac;
		logic [31:0] want_src_ip;
		logic [31:0] want_dst_ip;
		logic [15:0] want_src_port;
		logic [15:0] want_dst_port;
	} cfg_t;

	typedef struct packed {
		logic [7:0]         protocol;
		logic [3:0]         header_words;
		logic [47:0]        dst_mac;
		logic [47:0]        src_mac;
		logic [31:0]        src_ip;
		logic [31:0]        dst_ip;
		logic [15:0]        src_port;
		logic [15:0]        dst_port;
		logic [AVAIL_W-1:0] avail;
	} frame_t;

endpackage

`default_nettype wire

>>> hdl/ehf_if.sv
// word channels of the filter: frame bytes in, verdicts out
`default_nettype none

interface ehf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ehf_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [1:0]  proto_class;
	logic [7:0]  ip_protocol;
	logic [31:0] total_count;
	logic [31:0] tcp_count;
	logic [31:0] udp_count;
	logic [31:0] other_count;

	modport source (output valid, output verdict, output proto_class, output ip_protocol,
		output total_count, output tcp_count, output udp_count, output other_count,
		input ready);
	modport sink (input valid, input verdict, input proto_class, input ip_protocol,
		input total_count, input tcp_count, input udp_count, input other_count,
		output ready);
endinterface

`default_nettype wire

>>> hdl/ehf_cfg.sv
// configuration register file of the filter
`default_nettype none

module ehf_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [ehf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ehf_pkg::CFG_DATA_W-1:0] cfg_data,
	output ehf_pkg::cfg_t                      cfg
);

	ehf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (ehf_pkg::reg_index_t'(cfg_index))
				ehf_pkg::REG_PROTOCOL_SELECT: cfg_q.protocol_select <= cfg_data[7:0];
				ehf_pkg::REG_MATCH_ENABLES:   cfg_q.match_enables <= cfg_data[3:0];
				ehf_pkg::REG_WANT_SRC_MAC:    cfg_q.want_src_mac <= cfg_data[47:0];
				ehf_pkg::REG_WANT_DST_MAC:    cfg_q.want_dst_mac <= cfg_data[47:0];
				ehf_pkg::REG_WANT_SRC_IP:     cfg_q.want_src_ip <= cfg_data[31:0];
				ehf_pkg::REG_WANT_DST_IP:     cfg_q.want_dst_ip <= cfg_data[31:0];
				ehf_pkg::REG_WANT_SRC_PORT:   cfg_q.want_src_port <= cfg_data[15:0];
				ehf_pkg::REG_WANT_DST_PORT:   cfg_q.want_dst_port <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/ehf_capture.sv
// header field capture: byte position tracking and field shift registers
`default_nettype none

module ehf_capture #(
	parameter int unsigned MAX_FRAME_BYTES = ehf_pkg::MAX_FRAME_BYTES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] frame_byte,
	input  wire logic       last_byte,
	output ehf_pkg::frame_t frame
);

	localparam logic [ehf_pkg::AVAIL_W-1:0] LIMIT = ehf_pkg::AVAIL_W'(MAX_FRAME_BYTES);

	logic [ehf_pkg::POS_W-1:0]   pos_q;
	logic [3:0]                  hw_q;
	logic [7:0]                  proto_q;
	logic [47:0]                 dmac_q;
	logic [47:0]                 smac_q;
	logic [31:0]                 sip_q;
	logic [31:0]                 dip_q;
	logic [15:0]                 sport_q;
	logic [15:0]                 dport_q;

	logic                        in_range;
	logic                        port_zone;
	logic [6:0]                  l4_start;
	logic [ehf_pkg::POS_W-1:0]   l4_pos;
	logic [ehf_pkg::AVAIL_W-1:0] seen_bytes;
	ehf_pkg::frame_t             nxt;

	always_comb begin
		in_range = {1'b0, pos_q} < LIMIT;
		l4_start = 7'd14 + {1'b0, hw_q, 2'b00};
		l4_pos = ehf_pkg::POS_W'(l4_start);
		port_zone = in_range && (pos_q > 16'd14) && (hw_q >= ehf_pkg::MIN_HEADER_WORDS);
		seen_bytes = {1'b0, pos_q} + 17'd1;

		nxt.dst_mac = dmac_q;
		nxt.src_mac = smac_q;
		nxt.header_words = hw_q;
		nxt.protocol = proto_q;
		nxt.src_ip = sip_q;
		nxt.dst_ip = dip_q;
		nxt.src_port = sport_q;
		nxt.dst_port = dport_q;
		nxt.avail = (seen_bytes > LIMIT) ? LIMIT : seen_bytes;

		if (in_range) begin
			if (pos_q <= 16'd5) begin
				nxt.dst_mac = {dmac_q[39:0], frame_byte};
			end else if (pos_q <= 16'd11) begin
				nxt.src_mac = {smac_q[39:0], frame_byte};
			end else if (pos_q == 16'd14) begin
				nxt.header_words = frame_byte[3:0];
			end else if (pos_q == 16'd23) begin
				nxt.protocol = frame_byte;
			end else if (pos_q >= 16'd26 && pos_q <= 16'd29) begin
				nxt.src_ip = {sip_q[23:0], frame_byte};
			end else if (pos_q >= 16'd30 && pos_q <= 16'd33) begin
				nxt.dst_ip = {dip_q[23:0], frame_byte};
			end
		end

		if (port_zone) begin
			if (pos_q == l4_pos || pos_q == l4_pos + 16'd1) begin
				nxt.src_port = {sport_q[7:0], frame_byte};
			end else if (pos_q == l4_pos + 16'd2 || pos_q == l4_pos + 16'd3) begin
				nxt.dst_port = {dport_q[7:0], frame_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hw_q <= '0;
			proto_q <= '0;
			dmac_q <= '0;
			smac_q <= '0;
			sip_q <= '0;
			dip_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q <= '0;
				hw_q <= '0;
				proto_q <= '0;
				dmac_q <= '0;
				smac_q <= '0;
				sip_q <= '0;
				dip_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				pos_q <= (pos_q != '1) ? pos_q + 16'd1 : pos_q;
				hw_q <= nxt.header_words;
				proto_q <= nxt.protocol;
				dmac_q <= nxt.dst_mac;
				smac_q <= nxt.src_mac;
				sip_q <= nxt.src_ip;
				dip_q <= nxt.dst_ip;
				sport_q <= nxt.src_port;
				dport_q <= nxt.dst_port;
			end
		end
	end

	assign frame = nxt;

endmodule

`default_nettype wire

>>> hdl/ehf_verdict.sv
// verdict decision, frame counters and result register
`default_nettype none

module ehf_verdict (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  ehf_pkg::frame_t  frame,
	input  ehf_pkg::cfg_t    cfg,
	output logic             can_take,
	ehf_result_if.source     result
);

	logic                 valid_q;
	ehf_pkg::verdict_t    verdict_q;
	ehf_pkg::class_t      class_q;
	logic [7:0]           proto_out_q;
	logic [31:0]          total_q;
	logic [31:0]          tcp_q;
	logic [31:0]          udp_q;
	logic [31:0]          other_q;

	ehf_pkg::verdict_t    v_n;
	ehf_pkg::class_t      c_n;
	logic [7:0]           p_n;
	logic [6:0]           need;
	logic                 ok;

	always_comb begin
		need = 7'd18 + {1'b0, frame.header_words, 2'b00};
		ok = 1'b1;
		if (cfg.match_enables[0] && frame.src_mac != cfg.want_src_mac) ok = 1'b0;
		if (cfg.match_enables[1] && frame.dst_mac != cfg.want_dst_mac) ok = 1'b0;
		if (cfg.match_enables[2] && frame.src_ip != cfg.want_src_ip) ok = 1'b0;
		if (cfg.match_enables[3] && frame.dst_ip != cfg.want_dst_ip) ok = 1'b0;
		if (cfg.want_src_port != 16'd0 && frame.src_port != cfg.want_src_port) ok = 1'b0;
		if (cfg.want_dst_port != 16'd0 && frame.dst_port != cfg.want_dst_port) ok = 1'b0;

		v_n = ehf_pkg::VERDICT_ACCEPT;
		c_n = ehf_pkg::CLASS_NONE;
		p_n = frame.protocol;
		if (frame.avail < ehf_pkg::MIN_DECODE_BYTES) begin
			v_n = ehf_pkg::VERDICT_TRUNCATED;
			p_n = 8'd0;
		end else if (cfg.protocol_select != 8'd0 && cfg.protocol_select != frame.protocol) begin
			v_n = ehf_pkg::VERDICT_PROTO_DROP;
		end else if (frame.protocol == ehf_pkg::PROTO_TCP
				|| frame.protocol == ehf_pkg::PROTO_UDP) begin
			c_n = (frame.protocol == ehf_pkg::PROTO_TCP) ? ehf_pkg::CLASS_TCP
				: ehf_pkg::CLASS_UDP;
			if (frame.header_words < ehf_pkg::MIN_HEADER_WORDS
					|| frame.avail < {10'd0, need}) begin
				v_n = ehf_pkg::VERDICT_TRUNCATED;
			end else begin
				v_n = ok ? ehf_pkg::VERDICT_ACCEPT : ehf_pkg::VERDICT_MATCH_DROP;
			end
		end else begin
			c_n = ehf_pkg::CLASS_OTHER;
		end
	end

	assign can_take = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			total_q <= '0;
			tcp_q <= '0;
			udp_q <= '0;
			other_q <= '0;
		end else if (fire) begin
			valid_q <= 1'b1;
			total_q <= total_q + 32'd1;
			if (c_n == ehf_pkg::CLASS_TCP) tcp_q <= tcp_q + 32'd1;
			if (c_n == ehf_pkg::CLASS_UDP) udp_q <= udp_q + 32'd1;
			if (c_n == ehf_pkg::CLASS_OTHER) other_q <= other_q + 32'd1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			verdict_q <= v_n;
			class_q <= c_n;
			proto_out_q <= p_n;
		end
	end

	assign result.valid = valid_q;
	assign result.verdict = verdict_q;
	assign result.proto_class = class_q;
	assign result.ip_protocol = proto_out_q;
	assign result.total_count = total_q;
	assign result.tcp_count = tcp_q;
	assign result.udp_count = udp_q;
	assign result.other_count = other_q;

endmodule

`default_nettype wire

>>> hdl/ethernet_ipv4_l4_header_filter_unit.sv
// top level of the ethernet ipv4 l4 header filter
// The filter takes one frame byte per cycle on the frame channel, starting at the destination
// MAC, and gives one result word on the result channel for each byte marked last: verdict,
// protocol class, the IPv4 protocol byte and the four frame counters after that frame. A byte
// is held in the input register and is decoded into the header capture registers as it
// leaves, and a last byte's verdict is loaded into the result register at that same edge.
// Sustained rate is one byte per cycle; the only stall comes from the result register when a
// verdict is still waiting to be taken and another last byte reaches the decode stage.
// Configuration is written through the plain write port; the user must do so only while no
// frame is in flight, as the block itself does not enforce it.
`default_nettype none

module ethernet_ipv4_l4_header_filter_unit #(
	parameter int unsigned MAX_FRAME_BYTES = ehf_pkg::MAX_FRAME_BYTES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [ehf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ehf_pkg::CFG_DATA_W-1:0] cfg_data,
	ehf_byte_if.sink                           frame,
	ehf_result_if.source                       result
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic            advance;
	logic            can_take;
	ehf_pkg::cfg_t   cfg;
	ehf_pkg::frame_t fields;

	assign advance = valid_s1 && (!last_s1 || can_take);
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.frame_byte;
			last_s1 <= frame.last_byte;
		end
	end

	ehf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ehf_capture #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.frame      (fields)
	);

	ehf_verdict u_verdict (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance && last_s1),
		.frame    (fields),
		.cfg      (cfg),
		.can_take (can_take),
		.result   (result)
	);

endmodule

`default_nettype wire

>>> tb/ethernet_ipv4_l4_header_filter_unit_test.sv
// self-checking testbench of the ethernet ipv4 l4 header filter: directed and random frames
module ethernet_ipv4_l4_header_filter_unit_test;
	import ehf_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SEGMENT_BYTES = 240;

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} hdr_fields_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} frame_word_t;

	typedef struct {
		verdict_t    verdict;
		class_t      proto_class;
		logic [7:0]  ip_protocol;
		logic [31:0] total_count;
		logic [31:0] tcp_count;
		logic [31:0] udp_count;
		logic [31:0] other_count;
	} verdict_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	reg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ehf_byte_if   frame_ch();
	ehf_result_if result_ch();

	ethernet_ipv4_l4_header_filter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.frame(frame_ch),
		.result(result_ch)
	);

	// filter state as the predictor sees it
	cfg_t        active_cfg = '0;
	logic [15:0] frame_pos = '0;
	logic [3:0]  seen_ihl = '0;
	logic [7:0]  seen_proto = '0;
	logic [47:0] seen_dmac = '0;
	logic [47:0] seen_smac = '0;
	logic [31:0] seen_sip = '0;
	logic [31:0] seen_dip = '0;
	logic [15:0] seen_sport = '0;
	logic [15:0] seen_dport = '0;
	logic [31:0] n_total = '0;
	logic [31:0] n_tcp = '0;
	logic [31:0] n_udp = '0;
	logic [31:0] n_other = '0;

	frame_word_t   byte_queue[$];
	logic [7:0]    frame_buf[$];
	verdict_word_t pending_verdicts[$];
	frame_word_t   next_word;
	verdict_word_t next_verdict;

	int bytes_queued = 0;
	int bytes_taken = 0;
	int frames_queued = 0;
	int configs_applied = 0;
	int verdicts_checked = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int verdict_tally[4] = '{0, 0, 0, 0};

	always #5 clk = ~clk;

	function automatic void filter_byte(input logic [7:0] b, input logic last);
		int idx;
		int l4;
		int avail;
		logic ok;
		verdict_word_t w;
		idx = int'(frame_pos);
		if (idx < int'(MAX_FRAME_BYTES)) begin
			if (idx <= 5) seen_dmac = {seen_dmac[39:0], b};
			else if (idx <= 11) seen_smac = {seen_smac[39:0], b};
			else if (idx == 14) seen_ihl = b[3:0];
			else if (idx == 23) seen_proto = b;
			else if (idx >= 26 && idx <= 29) seen_sip = {seen_sip[23:0], b};
			else if (idx >= 30 && idx <= 33) seen_dip = {seen_dip[23:0], b};
			if (idx > 14 && seen_ihl >= MIN_HEADER_WORDS) begin
				l4 = 14 + 4 * int'(seen_ihl);
				if (idx == l4 || idx == l4 + 1) seen_sport = {seen_sport[7:0], b};
				else if (idx == l4 + 2 || idx == l4 + 3) seen_dport = {seen_dport[7:0], b};
			end
		end
		if (frame_pos != 16'hFFFF) frame_pos++;
		if (!last) return;

		avail = (idx + 1 > int'(MAX_FRAME_BYTES)) ? int'(MAX_FRAME_BYTES) : idx + 1;
		n_total++;
		w.verdict = VERDICT_TRUNCATED;
		w.proto_class = CLASS_NONE;
		w.ip_protocol = 8'd0;
		if (avail >= int'(MIN_DECODE_BYTES)) begin
			w.ip_protocol = seen_proto;
			if (active_cfg.protocol_select != 8'd0 && active_cfg.protocol_select != seen_proto) begin
				w.verdict = VERDICT_PROTO_DROP;
			end else if (seen_proto == PROTO_TCP || seen_proto == PROTO_UDP) begin
				if (seen_proto == PROTO_TCP) begin
					w.proto_class = CLASS_TCP;
					n_tcp++;
				end else begin
					w.proto_class = CLASS_UDP;
					n_udp++;
				end
				if (seen_ihl < MIN_HEADER_WORDS || avail < 18 + 4 * int'(seen_ihl)) begin
					w.verdict = VERDICT_TRUNCATED;
				end else begin
					ok = 1'b1;
					if (active_cfg.match_enables[0] && seen_smac != active_cfg.want_src_mac) ok = 1'b0;
					if (active_cfg.match_enables[1] && seen_dmac != active_cfg.want_dst_mac) ok = 1'b0;
					if (active_cfg.match_enables[2] && seen_sip != active_cfg.want_src_ip) ok = 1'b0;
					if (active_cfg.match_enables[3] && seen_dip != active_cfg.want_dst_ip) ok = 1'b0;
					if (active_cfg.want_src_port != 16'd0 && seen_sport != active_cfg.want_src_port)
						ok = 1'b0;
					if (active_cfg.want_dst_port != 16'd0 && seen_dport != active_cfg.want_dst_port)
						ok = 1'b0;
					w.verdict = ok ? VERDICT_ACCEPT : VERDICT_MATCH_DROP;
				end
			end else begin
				w.proto_class = CLASS_OTHER;
				n_other++;
				w.verdict = VERDICT_ACCEPT;
			end
		end
		w.total_count = n_total;
		w.tcp_count = n_tcp;
		w.udp_count = n_udp;
		w.other_count = n_other;
		pending_verdicts.push_back(w);

		frame_pos = '0;
		seen_ihl = '0;
		seen_proto = '0;
		seen_dmac = '0;
		seen_smac = '0;
		seen_sip = '0;
		seen_dip = '0;
		seen_sport = '0;
		seen_dport = '0;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// frame byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
			frame_ch.frame_byte <= 8'd0;
			frame_ch.last_byte <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				filter_byte(frame_ch.frame_byte, frame_ch.last_byte);
				bytes_taken++;
			end
			if (!frame_ch.valid || frame_ch.ready) begin
				if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = byte_queue.pop_front();
					frame_ch.valid <= 1'b1;
					frame_ch.frame_byte <= next_word.data;
					frame_ch.last_byte <= next_word.last;
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// verdict monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: unexpected verdict word, expected none actual verdict %0d",
						$time, result_ch.verdict);
					mismatches++;
				end else begin
					next_verdict = pending_verdicts.pop_front();
					check_field("verdict", 32'(next_verdict.verdict), 32'(result_ch.verdict));
					check_field("proto_class", 32'(next_verdict.proto_class),
						32'(result_ch.proto_class));
					check_field("ip_protocol", 32'(next_verdict.ip_protocol),
						32'(result_ch.ip_protocol));
					check_field("total_count", next_verdict.total_count, result_ch.total_count);
					check_field("tcp_count", next_verdict.tcp_count, result_ch.tcp_count);
					check_field("udp_count", next_verdict.udp_count, result_ch.udp_count);
					check_field("other_count", next_verdict.other_count, result_ch.other_count);
					verdict_tally[next_verdict.verdict]++;
					verdicts_checked++;
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [47:0] value, input int width);
		logic [47:0] keep;
		keep = (width >= 48) ? '1 : ((48'd1 << width) - 48'd1);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (48'({$urandom, $urandom}) & ~keep) | (value & keep);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_config(input cfg_t c);
		write_reg(REG_PROTOCOL_SELECT, 48'(c.protocol_select), 8);
		write_reg(REG_MATCH_ENABLES, 48'(c.match_enables), 4);
		write_reg(REG_WANT_SRC_MAC, c.want_src_mac, 48);
		write_reg(REG_WANT_DST_MAC, c.want_dst_mac, 48);
		write_reg(REG_WANT_SRC_IP, 48'(c.want_src_ip), 32);
		write_reg(REG_WANT_DST_IP, 48'(c.want_dst_ip), 32);
		write_reg(REG_WANT_SRC_PORT, 48'(c.want_src_port), 16);
		write_reg(REG_WANT_DST_PORT, 48'(c.want_dst_port), 16);
		active_cfg = c;
		configs_applied++;
	endtask

	task automatic wait_for_verdicts();
		while (bytes_taken != bytes_queued || pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void put_byte(input int pos, input logic [7:0] v);
		if (pos < frame_buf.size()) frame_buf[pos] = v;
	endfunction

	function automatic hdr_fields_t wanted_fields();
		hdr_fields_t f;
		f.dst_mac = active_cfg.want_dst_mac;
		f.src_mac = active_cfg.want_src_mac;
		f.src_ip = active_cfg.want_src_ip;
		f.dst_ip = active_cfg.want_dst_ip;
		f.src_port = active_cfg.want_src_port;
		f.dst_port = active_cfg.want_dst_port;
		return f;
	endfunction

	// fill < 0 means random filler bytes
	task automatic make_frame(input int len, input logic [7:0] proto, input logic [3:0] ihl,
			input hdr_fields_t f, input int fill);
		int l4;
		frame_buf.delete();
		for (int i = 0; i < len; i++) frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		for (int i = 0; i < 6; i++) begin
			put_byte(i, f.dst_mac[47 - 8*i -: 8]);
			put_byte(6 + i, f.src_mac[47 - 8*i -: 8]);
		end
		if (len > 14) put_byte(14, {frame_buf[14][7:4], ihl});
		put_byte(23, proto);
		for (int i = 0; i < 4; i++) begin
			put_byte(26 + i, f.src_ip[31 - 8*i -: 8]);
			put_byte(30 + i, f.dst_ip[31 - 8*i -: 8]);
		end
		if (ihl >= MIN_HEADER_WORDS) begin
			l4 = 14 + 4 * int'(ihl);
			put_byte(l4, f.src_port[15:8]);
			put_byte(l4 + 1, f.src_port[7:0]);
			put_byte(l4 + 2, f.dst_port[15:8]);
			put_byte(l4 + 3, f.dst_port[7:0]);
		end
		for (int i = 0; i < len; i++) byte_queue.push_back('{frame_buf[i], i == len - 1});
		bytes_queued += len;
		frames_queued++;
	endtask

	task automatic random_frame();
		hdr_fields_t f;
		logic [7:0] proto;
		logic [3:0] ihl;
		int pick;
		int l4_end;
		f = wanted_fields();
		if ($urandom_range(99) < 20) begin
			// noise
			f = hdr_fields_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			make_frame($urandom_range(1, 40), 8'($urandom), 4'($urandom), f, -1);
		end else begin
			pick = $urandom_range(9);
			proto = pick < 4 ? PROTO_TCP : pick < 8 ? PROTO_UDP :
				pick == 8 ? active_cfg.protocol_select : 8'($urandom);
			pick = $urandom_range(9);
			ihl = pick < 8 ? MIN_HEADER_WORDS : pick == 8 ? 4'($urandom_range(5, 15)) : 4'($urandom);
			if ($urandom_range(5) == 0) f.dst_mac ^= 48'd1 << $urandom_range(47);
			if ($urandom_range(5) == 0) f.src_mac ^= 48'd1 << $urandom_range(47);
			if ($urandom_range(5) == 0) f.src_ip ^= 32'd1 << $urandom_range(31);
			if ($urandom_range(5) == 0) f.dst_ip ^= 32'd1 << $urandom_range(31);
			if ($urandom_range(5) == 0) f.src_port ^= 16'd1 << $urandom_range(15);
			if ($urandom_range(5) == 0) f.dst_port ^= 16'd1 << $urandom_range(15);
			l4_end = 18 + 4 * int'(ihl);
			if ($urandom_range(6) == 0) make_frame($urandom_range(1, l4_end - 1), proto, ihl, f, -1);
			else make_frame(l4_end + $urandom_range(0, 10), proto, ihl, f, -1);
		end
	endtask

	task automatic random_segment(input cfg_t c);
		int start_bytes;
		int frames;
		wait_for_verdicts();
		apply_config(c);
		start_bytes = bytes_queued;
		frames = 0;
		while (bytes_queued - start_bytes < SEGMENT_BYTES || frames < 4) begin
			random_frame();
			frames++;
			// let the filter drain completely now and then
			if (frames % 5 == 0) wait_for_verdicts();
		end
	endtask

	initial begin
		cfg_t plan;
		hdr_fields_t f;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_PROTOCOL_SELECT;
		cfg_data = '0;
		send_idle_pct = 38;
		recv_idle_pct = 49;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all registers at zero: every protocol passes, no address or port checks
		plan = '0;
		apply_config(plan);
		make_frame(1, PROTO_TCP, MIN_HEADER_WORDS, wanted_fields(), -1);
		make_frame(23, PROTO_TCP, MIN_HEADER_WORDS, wanted_fields(), -1);
		make_frame(24, PROTO_TCP, MIN_HEADER_WORDS, wanted_fields(), -1);
		make_frame(37, PROTO_TCP, MIN_HEADER_WORDS, wanted_fields(), -1);
		make_frame(38, PROTO_TCP, MIN_HEADER_WORDS, wanted_fields(), -1);
		make_frame(78, PROTO_UDP, 4'd15, wanted_fields(), -1);
		make_frame(60, PROTO_TCP, 4'd4, wanted_fields(), -1);
		make_frame(30, 8'd1, MIN_HEADER_WORDS, wanted_fields(), -1);
		make_frame(24, 8'd0, MIN_HEADER_WORDS, wanted_fields(), -1);
		f = '1;
		make_frame(64, 8'hFF, 4'd15, f, 8'hFF);
		make_frame(60, 8'd0, 4'd0, wanted_fields(), 0);

		// strict tcp filter with every match enabled
		wait_for_verdicts();
		plan.protocol_select = PROTO_TCP;
		plan.match_enables = 4'hF;
		plan.want_src_mac = 48'({$urandom, $urandom});
		plan.want_dst_mac = 48'({$urandom, $urandom});
		plan.want_src_ip = $urandom;
		plan.want_dst_ip = $urandom;
		plan.want_src_port = 16'($urandom_range(1, 65535));
		plan.want_dst_port = 16'($urandom_range(1, 65535));
		apply_config(plan);
		make_frame(38, PROTO_TCP, MIN_HEADER_WORDS, wanted_fields(), -1);
		for (int k = 0; k < 6; k++) begin
			f = wanted_fields();
			case (k)
				0: f.src_mac ^= 48'd1 << $urandom_range(47);
				1: f.dst_mac ^= 48'd1 << $urandom_range(47);
				2: f.src_ip ^= 32'd1 << $urandom_range(31);
				3: f.dst_ip ^= 32'd1 << $urandom_range(31);
				4: f.src_port ^= 16'd1 << $urandom_range(15);
				default: f.dst_port ^= 16'd1 << $urandom_range(15);
			endcase
			make_frame(38 + $urandom_range(0, 4), PROTO_TCP, MIN_HEADER_WORDS, f, -1);
		end
		make_frame(40, PROTO_UDP, MIN_HEADER_WORDS, wanted_fields(), -1);
		make_frame(78, PROTO_TCP, 4'd15, wanted_fields(), -1);

		random_segment(plan);

		send_idle_pct = 49;
		recv_idle_pct = 38;
		wait_for_verdicts();
		plan.protocol_select = PROTO_UDP;
		plan.match_enables = 4'($urandom);
		plan.want_src_mac = 48'({$urandom, $urandom});
		plan.want_dst_mac = 48'({$urandom, $urandom});
		plan.want_src_ip = $urandom;
		plan.want_dst_ip = $urandom;
		plan.want_src_port = 16'($urandom_range(1, 65535));
		plan.want_dst_port = 16'd0;
		random_segment(plan);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		plan = '1;
		random_segment(plan);
		plan.protocol_select = 8'd0;
		random_segment(plan);
		random_frame();

		wait_for_verdicts();
		$display("%0d frames in %0d bytes under %0d register settings, %0d verdict words checked",
			frames_queued, bytes_queued, configs_applied, verdicts_checked);
		$display("verdicts seen: accepted %0d, protocol dropped %0d, match dropped %0d, truncated %0d",
			verdict_tally[VERDICT_ACCEPT], verdict_tally[VERDICT_PROTO_DROP],
			verdict_tally[VERDICT_MATCH_DROP], verdict_tally[VERDICT_TRUNCATED]);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
